>>> rtl/core/dupwc_pkg.sv
// ----------------------------------------------------------------------------
// dupwc_pkg
// Shared types and constants of the dual up/down potentiometer wiper
// controller: field widths, resistance range, tap limits, channel phases
// and the reciprocal used to turn ohms into a target tap.
// ----------------------------------------------------------------------------
`default_nettype none

package dupwc_pkg;

    // Field widths
    localparam int OHMS_W = 14;
    localparam int TAP_W  = 8;
    localparam int SEL_W  = 2;
    localparam int NCHAN  = 2;

    // Resistance range and tap limits
    localparam int MAX_OHMS = 10000;
    localparam int MIN_OHMS = 0;
    localparam int TOP_TAP  = 255;
    localparam int MID_TAP  = 128;

    // Request opcodes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Target tap = floor(ohms * TOP_TAP / MAX_OHMS) as a multiply by a rounded-up
    // reciprocal. The shift keeps the error below 1/MAX_OHMS for every ohms up
    // to MAX_OHMS, so the floor is exact.
    localparam int RECIP_SHIFT = 28;
    localparam longint unsigned RECIP_MULT =
        ((longint'(TOP_TAP) << RECIP_SHIFT) + longint'(MAX_OHMS) - 1) / longint'(MAX_OHMS);
    localparam int RECIP_W = $clog2(RECIP_MULT + 1);
    localparam int PROD_W  = OHMS_W + RECIP_W;

    // Per-channel sequencing phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SETUP1 = 3'd1,
        PH_SETUP2 = 3'd2,
        PH_RUN    = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    // One captured input request
    typedef struct packed {
        logic              opcode;
        logic [SEL_W-1:0]  chan_sel;
        logic [OHMS_W-1:0] ohms;
    } req_t;

    // One result
    typedef struct packed {
        logic             request_ok;
        logic             cs_a_pin;
        logic             ud_a_pin;
        logic             inc_a_pin;
        logic             cs_b_pin;
        logic             ud_b_pin;
        logic             inc_b_pin;
        logic [TAP_W-1:0] tap_a_now;
        logic [TAP_W-1:0] tap_b_now;
        logic             all_done;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/dual_updown_pot_wiper_controller.sv
// ----------------------------------------------------------------------------
// dual_updown_pot_wiper_controller
// Drives two up/down-interface digital potentiometers from resistance
// requests and timer ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready): s_opcode 0 is a resistance request for
//   channel s_chan_sel (0 = A, 1 = B) with s_ohms; s_opcode 1 is one timer tick
//   that advances chip select, the shared INC line and the running wipers.
//   Result channel (m_valid/m_ready): one result per request, giving whether
//   the request was taken, the pin levels, both wiper taps and all_done.
//   Path: the request is taken into the input register, and the state
//   update then loads the result register, or the skid register when the
//   result register is full and not being popped.
//   Throughput: 1 request per cycle while the skid is empty; the state update
//   is a single pass of logic, the target tap comes from one constant multiply.
//   Stall: a two-entry result buffer (result register plus skid) holds
//   finished results; once both are full the input register still takes one
//   more request, then s_ready drops and everything holds.
//   Reset (aresetn low, synchronous): both channels idle and deselected,
//   wipers and targets at mid tap, INC high, all buffers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_updown_pot_wiper_controller (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_opcode,
    input  wire logic [dupwc_pkg::SEL_W-1:0]   s_chan_sel,
    input  wire logic [dupwc_pkg::OHMS_W-1:0]  s_ohms,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_request_ok,
    output logic                               m_cs_a_pin,
    output logic                               m_ud_a_pin,
    output logic                               m_inc_a_pin,
    output logic                               m_cs_b_pin,
    output logic                               m_ud_b_pin,
    output logic                               m_inc_b_pin,
    output logic [dupwc_pkg::TAP_W-1:0]        m_tap_a_now,
    output logic [dupwc_pkg::TAP_W-1:0]        m_tap_b_now,
    output logic                               m_all_done
);

    localparam int TAP_W = dupwc_pkg::TAP_W;

    // Input stage
    logic              in_valid_reg;
    dupwc_pkg::req_t   in_reg;

    // Channel state
    dupwc_pkg::phase_t [dupwc_pkg::NCHAN-1:0] phase_reg, phase_next;
    logic [dupwc_pkg::NCHAN-1:0][TAP_W-1:0]   wiper_reg, wiper_next;
    logic [dupwc_pkg::NCHAN-1:0][TAP_W-1:0]   goal_reg, goal_next;
    logic [dupwc_pkg::NCHAN-1:0]              up_reg, up_next;
    logic [dupwc_pkg::NCHAN-1:0]              seln_reg, seln_next;
    logic                                     inc_reg, inc_next;
    logic                                     half_reg, half_next;

    // Result buffer
    logic                 out_valid_reg;
    dupwc_pkg::result_t   out_reg;
    logic                 skid_valid_reg;
    dupwc_pkg::result_t   skid_reg;

    logic                 advance;
    logic                 pop;
    dupwc_pkg::result_t   res;

    logic [dupwc_pkg::PROD_W-1:0] prod;
    logic [TAP_W-1:0]             target;
    logic                         range_ok;

    // Flow control
    assign pop     = out_valid_reg && m_ready;
    assign advance = in_valid_reg && !skid_valid_reg;
    assign s_ready = !in_valid_reg || advance;

    // Target tap by reciprocal multiply
    assign prod   = dupwc_pkg::PROD_W'(in_reg.ohms) *
                    dupwc_pkg::PROD_W'(dupwc_pkg::RECIP_MULT);
    assign target = prod[dupwc_pkg::RECIP_SHIFT +: TAP_W];

    assign range_ok = (in_reg.chan_sel <= dupwc_pkg::SEL_W'(1)) &&
                      (in_reg.ohms >= dupwc_pkg::OHMS_W'(dupwc_pkg::MIN_OHMS)) &&
                      (in_reg.ohms <= dupwc_pkg::OHMS_W'(dupwc_pkg::MAX_OHMS));

    // Next channel state and the result it shows
    always_comb begin
        logic [dupwc_pkg::NCHAN-1:0] busy;
        logic [dupwc_pkg::NCHAN-1:0] was_run;
        logic                        toggling;
        logic                        falling;
        logic                        ch;

        phase_next = phase_reg;
        wiper_next = wiper_reg;
        goal_next  = goal_reg;
        up_next    = up_reg;
        seln_next  = seln_reg;
        inc_next   = inc_reg;
        half_next  = half_reg;
        toggling   = 1'b0;
        falling    = 1'b0;
        was_run    = '0;
        ch         = in_reg.chan_sel[0];
        res        = '0;

        for (int c = 0; c < dupwc_pkg::NCHAN; c++) begin
            busy[c] = (phase_reg[c] == dupwc_pkg::PH_SETUP1) ||
                      (phase_reg[c] == dupwc_pkg::PH_SETUP2) ||
                      (phase_reg[c] == dupwc_pkg::PH_RUN);
        end

        if (in_reg.opcode == dupwc_pkg::OP_REQUEST) begin
            // Take a new target for the selected channel
            if (range_ok) begin
                res.request_ok = 1'b1;
                goal_next[ch]  = target;
                up_next[ch]    = target > wiper_reg[ch];
                if (target == wiper_reg[ch]) begin
                    phase_next[ch] = dupwc_pkg::PH_DONE;
                    seln_next[ch]  = 1'b1;
                end else if (!busy[ch]) begin
                    phase_next[ch] = dupwc_pkg::PH_SETUP1;
                    inc_next       = 1'b1;
                end
            end
        end else if (busy != '0) begin
            // Half period: lower chip selects, then move them to setup2
            half_next = !half_reg;
            for (int c = 0; c < dupwc_pkg::NCHAN; c++) begin
                if (phase_reg[c] == dupwc_pkg::PH_SETUP1) begin
                    if (!half_reg) begin
                        seln_next[c] = 1'b0;
                    end else if (!seln_reg[c]) begin
                        phase_next[c] = dupwc_pkg::PH_SETUP2;
                    end
                end
            end
            for (int c = 0; c < dupwc_pkg::NCHAN; c++) begin
                was_run[c] = phase_next[c] == dupwc_pkg::PH_RUN;
                if ((phase_next[c] == dupwc_pkg::PH_SETUP2) ||
                    (phase_next[c] == dupwc_pkg::PH_RUN)) begin
                    toggling = 1'b1;
                end
            end
            // Toggle INC; step running wipers on its falling edge
            if (toggling) begin
                inc_next = !inc_reg;
                falling  = inc_reg;
                for (int c = 0; c < dupwc_pkg::NCHAN; c++) begin
                    if (was_run[c]) begin
                        if (falling) begin
                            if (up_reg[c]) begin
                                if (wiper_reg[c] < TAP_W'(dupwc_pkg::TOP_TAP)) begin
                                    wiper_next[c] = wiper_reg[c] + TAP_W'(1);
                                end
                            end else if (wiper_reg[c] != '0) begin
                                wiper_next[c] = wiper_reg[c] - TAP_W'(1);
                            end
                        end
                        if (wiper_next[c] == goal_reg[c]) begin
                            phase_next[c] = dupwc_pkg::PH_DONE;
                            seln_next[c]  = 1'b1;
                        end
                    end else if (phase_next[c] == dupwc_pkg::PH_SETUP2) begin
                        phase_next[c] = dupwc_pkg::PH_RUN;
                    end
                end
            end
        end

        // Build the result from the updated state
        for (int c = 0; c < dupwc_pkg::NCHAN; c++) begin
            busy[c] = (phase_next[c] == dupwc_pkg::PH_SETUP1) ||
                      (phase_next[c] == dupwc_pkg::PH_SETUP2) ||
                      (phase_next[c] == dupwc_pkg::PH_RUN);
        end
        res.cs_a_pin  = seln_next[0];
        res.ud_a_pin  = up_next[0];
        res.inc_a_pin = busy[0] ? inc_next : 1'b1;
        res.cs_b_pin  = seln_next[1];
        res.ud_b_pin  = up_next[1];
        res.inc_b_pin = busy[1] ? inc_next : 1'b1;
        res.tap_a_now = wiper_next[0];
        res.tap_b_now = wiper_next[1];
        res.all_done  = (busy == '0);
    end

    // Capture requests
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_reg.opcode   <= s_opcode;
            in_reg.chan_sel <= s_chan_sel;
            in_reg.ohms     <= s_ohms;
        end
    end

    // Commit channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < dupwc_pkg::NCHAN; c++) begin
                phase_reg[c] <= dupwc_pkg::PH_IDLE;
                wiper_reg[c] <= TAP_W'(dupwc_pkg::MID_TAP);
                goal_reg[c]  <= TAP_W'(dupwc_pkg::MID_TAP);
            end
            up_reg   <= '0;
            seln_reg <= '1;
            inc_reg  <= 1'b1;
            half_reg <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            wiper_reg <= wiper_next;
            goal_reg  <= goal_next;
            up_reg    <= up_next;
            seln_reg  <= seln_next;
            inc_reg   <= inc_next;
            half_reg  <= half_next;
        end
    end

    // Result register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (advance) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (advance) begin
            if (!out_valid_reg || pop) begin
                out_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

    // Drive result ports
    assign m_valid      = out_valid_reg;
    assign m_request_ok = out_reg.request_ok;
    assign m_cs_a_pin   = out_reg.cs_a_pin;
    assign m_ud_a_pin   = out_reg.ud_a_pin;
    assign m_inc_a_pin  = out_reg.inc_a_pin;
    assign m_cs_b_pin   = out_reg.cs_b_pin;
    assign m_ud_b_pin   = out_reg.ud_b_pin;
    assign m_inc_b_pin  = out_reg.inc_b_pin;
    assign m_tap_a_now  = out_reg.tap_a_now;
    assign m_tap_b_now  = out_reg.tap_b_now;
    assign m_all_done   = out_reg.all_done;

endmodule

`default_nettype wire

>>> rtl/core/dupwc_checker.sv
// ----------------------------------------------------------------------------
// dupwc_checker
// Port-level checks of the wiper controller: result hold under stall and
// consistency of chip select, INC and all_done.
// ----------------------------------------------------------------------------
`default_nettype none

module dupwc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic                          m_request_ok,
    input wire logic                          m_cs_a_pin,
    input wire logic                          m_inc_a_pin,
    input wire logic                          m_cs_b_pin,
    input wire logic                          m_inc_b_pin,
    input wire logic [dupwc_pkg::TAP_W-1:0]   m_tap_a_now,
    input wire logic [dupwc_pkg::TAP_W-1:0]   m_tap_b_now,
    input wire logic                          m_all_done
);

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_request_ok) &&
        $stable(m_tap_a_now) && $stable(m_tap_b_now) && $stable(m_all_done))
        else $error("stalled result changed");

    // A selected channel is still in its sequence
    a_cs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (!m_cs_a_pin || !m_cs_b_pin) |-> !m_all_done)
        else $error("chip select low while all channels done");

    // INC idles high when nothing moves
    a_inc_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_all_done |-> m_inc_a_pin && m_inc_b_pin)
        else $error("INC low with no channel moving");

    // Both selected channels see the same shared INC level
    a_inc_shared: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_cs_a_pin && !m_cs_b_pin |-> m_inc_a_pin == m_inc_b_pin)
        else $error("shared INC differs between channels");

endmodule

bind dual_updown_pot_wiper_controller dupwc_checker u_dupwc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_request_ok (m_request_ok),
    .m_cs_a_pin   (m_cs_a_pin),
    .m_inc_a_pin  (m_inc_a_pin),
    .m_cs_b_pin   (m_cs_b_pin),
    .m_inc_b_pin  (m_inc_b_pin),
    .m_tap_a_now  (m_tap_a_now),
    .m_tap_b_now  (m_tap_b_now),
    .m_all_done   (m_all_done)
);

`default_nettype wire

>>> tb/sv/dual_updown_pot_wiper_controller_test.sv
// ----------------------------------------------------------------------------
// dual_updown_pot_wiper_controller_test
// Self-checking bench for the dual up/down potentiometer wiper controller.
// A short table of requests and ticks covers the reset state, range rejects,
// targets already reached and retargeting a busy channel. A long random run
// of mostly ticks with near and far targets follows. Each result is checked
// field by field against the table for pinned rows, else against an in-bench
// model of both channels, with random idle on both handshakes.
// ----------------------------------------------------------------------------

module dual_updown_pot_wiper_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic                         op;
        logic [dupwc_pkg::SEL_W-1:0]  sel;
        logic [dupwc_pkg::OHMS_W-1:0] ohms;
        bit                           pinned;
        dupwc_pkg::result_t           want;
    } stim_row_t;

    logic                         aclk;
    logic                         aresetn    = 1'b0;
    logic                         s_valid    = 1'b0;
    logic                         s_ready;
    logic                         s_opcode   = dupwc_pkg::OP_TICK;
    logic [dupwc_pkg::SEL_W-1:0]  s_chan_sel = '0;
    logic [dupwc_pkg::OHMS_W-1:0] s_ohms     = '0;
    logic                         m_valid;
    logic                         m_ready    = 1'b0;
    logic                         m_request_ok;
    logic                         m_cs_a_pin;
    logic                         m_ud_a_pin;
    logic                         m_inc_a_pin;
    logic                         m_cs_b_pin;
    logic                         m_ud_b_pin;
    logic                         m_inc_b_pin;
    logic [dupwc_pkg::TAP_W-1:0]  m_tap_a_now;
    logic [dupwc_pkg::TAP_W-1:0]  m_tap_b_now;
    logic                         m_all_done;

    // Model state of both channels
    dupwc_pkg::phase_t           chan_ph [dupwc_pkg::NCHAN];
    logic [dupwc_pkg::TAP_W-1:0] wiper   [dupwc_pkg::NCHAN];
    logic [dupwc_pkg::TAP_W-1:0] target  [dupwc_pkg::NCHAN];
    logic                        dir_up  [dupwc_pkg::NCHAN];
    logic                        csn     [dupwc_pkg::NCHAN];
    logic                        inc_lvl;
    logic                        half_tick;

    dupwc_pkg::result_t pending_pins[$];
    bit                 cur_pinned = 1'b0;
    dupwc_pkg::result_t cur_want   = '0;
    bit                 no_idle    = 1'b0;
    int                 errors     = 0;
    int                 cycles     = 0;

    dual_updown_pot_wiper_controller uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_chan_sel  (s_chan_sel),
        .s_ohms      (s_ohms),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_request_ok(m_request_ok),
        .m_cs_a_pin  (m_cs_a_pin),
        .m_ud_a_pin  (m_ud_a_pin),
        .m_inc_a_pin (m_inc_a_pin),
        .m_cs_b_pin  (m_cs_b_pin),
        .m_ud_b_pin  (m_ud_b_pin),
        .m_inc_b_pin (m_inc_b_pin),
        .m_tap_a_now (m_tap_a_now),
        .m_tap_b_now (m_tap_b_now),
        .m_all_done  (m_all_done)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit chan_busy(int c);
        return chan_ph[c] == dupwc_pkg::PH_SETUP1 || chan_ph[c] == dupwc_pkg::PH_SETUP2 ||
               chan_ph[c] == dupwc_pkg::PH_RUN;
    endfunction

    // Apply one request or tick to the model and return the pins after it
    function automatic dupwc_pkg::result_t predict_pins(logic op,
                                                        logic [dupwc_pkg::SEL_W-1:0] sel,
                                                        logic [dupwc_pkg::OHMS_W-1:0] ohms);
        dupwc_pkg::result_t r;
        int      c;
        int      tap;
        bit      ok;
        bit      toggling;
        bit      falling;
        bit      was_run [dupwc_pkg::NCHAN];
        ok = 1'b0;
        if (op == dupwc_pkg::OP_REQUEST) begin
            if (sel <= 1 && int'(ohms) >= dupwc_pkg::MIN_OHMS &&
                int'(ohms) <= dupwc_pkg::MAX_OHMS) begin
                ok        = 1'b1;
                c         = int'(sel);
                tap       = (int'(ohms) * dupwc_pkg::TOP_TAP) / dupwc_pkg::MAX_OHMS;
                target[c] = tap[dupwc_pkg::TAP_W-1:0];
                dir_up[c] = target[c] > wiper[c];
                if (target[c] == wiper[c]) begin
                    chan_ph[c] = dupwc_pkg::PH_DONE;
                    csn[c]     = 1'b1;
                end else if (!chan_busy(c)) begin
                    chan_ph[c] = dupwc_pkg::PH_SETUP1;
                    inc_lvl    = 1'b1;
                end
            end
        end else if (chan_busy(0) || chan_busy(1)) begin
            // Alternate half periods: select first, then settle up/down
            if (half_tick) begin
                half_tick = 1'b0;
                for (c = 0; c < dupwc_pkg::NCHAN; c++)
                    if (chan_ph[c] == dupwc_pkg::PH_SETUP1 && !csn[c])
                        chan_ph[c] = dupwc_pkg::PH_SETUP2;
            end else begin
                for (c = 0; c < dupwc_pkg::NCHAN; c++)
                    if (chan_ph[c] == dupwc_pkg::PH_SETUP1)
                        csn[c] = 1'b0;
                half_tick = 1'b1;
            end
            toggling = 1'b0;
            for (c = 0; c < dupwc_pkg::NCHAN; c++) begin
                was_run[c] = chan_ph[c] == dupwc_pkg::PH_RUN;
                if (chan_ph[c] == dupwc_pkg::PH_SETUP2 || chan_ph[c] == dupwc_pkg::PH_RUN)
                    toggling = 1'b1;
            end
            // Toggle INC; step running wipers on a falling edge
            if (toggling) begin
                falling = inc_lvl;
                inc_lvl = ~inc_lvl;
                for (c = 0; c < dupwc_pkg::NCHAN; c++) begin
                    if (was_run[c]) begin
                        if (falling) begin
                            if (dir_up[c]) begin
                                if (wiper[c] < dupwc_pkg::TOP_TAP)
                                    wiper[c] = wiper[c] + 1'b1;
                            end else if (wiper[c] > 0) begin
                                wiper[c] = wiper[c] - 1'b1;
                            end
                        end
                        if (wiper[c] == target[c]) begin
                            chan_ph[c] = dupwc_pkg::PH_DONE;
                            csn[c]     = 1'b1;
                        end
                    end else if (chan_ph[c] == dupwc_pkg::PH_SETUP2) begin
                        chan_ph[c] = dupwc_pkg::PH_RUN;
                    end
                end
            end
        end
        r.request_ok = ok;
        r.cs_a_pin   = csn[0];
        r.ud_a_pin   = dir_up[0];
        r.inc_a_pin  = chan_busy(0) ? inc_lvl : 1'b1;
        r.cs_b_pin   = csn[1];
        r.ud_b_pin   = dir_up[1];
        r.inc_b_pin  = chan_busy(1) ? inc_lvl : 1'b1;
        r.tap_a_now  = wiper[0];
        r.tap_b_now  = wiper[1];
        r.all_done   = !chan_busy(0) && !chan_busy(1);
        return r;
    endfunction

    function automatic stim_row_t row_of(logic op, logic [dupwc_pkg::SEL_W-1:0] sel,
                                         logic [dupwc_pkg::OHMS_W-1:0] ohms);
        stim_row_t row;
        row.op     = op;
        row.sel    = sel;
        row.ohms   = ohms;
        row.pinned = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    function automatic stim_row_t pinned_row(logic op, logic [dupwc_pkg::SEL_W-1:0] sel,
                                             logic [dupwc_pkg::OHMS_W-1:0] ohms,
                                             dupwc_pkg::result_t want);
        stim_row_t row;
        row        = row_of(op, sel, ohms);
        row.pinned = 1'b1;
        row.want   = want;
        return row;
    endfunction

    // Smallest resistance that lands exactly on a given tap
    function automatic logic [dupwc_pkg::OHMS_W-1:0] ohms_for_tap(int t);
        return dupwc_pkg::OHMS_W'((t * dupwc_pkg::MAX_OHMS + dupwc_pkg::TOP_TAP - 1) /
                                  dupwc_pkg::TOP_TAP);
    endfunction

    // Mostly ticks, with near targets so channels finish, far targets and rejects
    function automatic stim_row_t random_row();
        stim_row_t row;
        int        pick;
        int        c;
        int        t;
        pick = $urandom_range(0, 99);
        c    = $urandom_range(0, 1);
        row  = row_of(dupwc_pkg::OP_TICK, dupwc_pkg::SEL_W'($urandom),
                      dupwc_pkg::OHMS_W'($urandom));
        if (pick >= 80 && pick < 88) begin
            t = int'(wiper[c]) + $urandom_range(0, 8) - 4;
            if (t < 0)
                t = 0;
            if (t > dupwc_pkg::TOP_TAP)
                t = dupwc_pkg::TOP_TAP;
            row = row_of(dupwc_pkg::OP_REQUEST, dupwc_pkg::SEL_W'(c), ohms_for_tap(t));
        end else if (pick >= 88 && pick < 94) begin
            row = row_of(dupwc_pkg::OP_REQUEST, dupwc_pkg::SEL_W'(c),
                         dupwc_pkg::OHMS_W'($urandom_range(dupwc_pkg::MIN_OHMS,
                                                           dupwc_pkg::MAX_OHMS)));
        end else if (pick >= 94 && pick < 96) begin
            row = row_of(dupwc_pkg::OP_REQUEST, dupwc_pkg::SEL_W'(c),
                         $urandom_range(0, 1) ? dupwc_pkg::OHMS_W'(dupwc_pkg::MAX_OHMS)
                                              : dupwc_pkg::OHMS_W'(dupwc_pkg::MIN_OHMS));
        end else if (pick >= 96) begin
            if ($urandom_range(0, 1))
                row = row_of(dupwc_pkg::OP_REQUEST, dupwc_pkg::SEL_W'($urandom_range(2, 3)),
                             dupwc_pkg::OHMS_W'($urandom_range(0, 16383)));
            else
                row = row_of(dupwc_pkg::OP_REQUEST, dupwc_pkg::SEL_W'(c),
                             dupwc_pkg::OHMS_W'($urandom_range(dupwc_pkg::MAX_OHMS + 1,
                                                               16383)));
        end
        return row;
    endfunction

    // Present one request at a falling edge and hold it until taken
    task automatic send_row(stim_row_t row);
        while (!no_idle && $urandom_range(0, 99) < 17) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        cur_pinned = row.pinned;
        cur_want   = row.want;
        s_opcode   <= row.op;
        s_chan_sel <= row.sel;
        s_ohms     <= row.ohms;
        s_valid    <= 1'b1;
        do
            @(posedge aclk);
        while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= 17);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Check taken results, then predict for taken requests
    always @(posedge aclk) begin
        dupwc_pkg::result_t want;
        if (aresetn) begin
            if (m_valid === 1'b1 && m_ready) begin
                if (pending_pins.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    want = pending_pins.pop_front();
                    check_field("request_ok", want.request_ok, m_request_ok);
                    check_field("cs_a_pin", want.cs_a_pin, m_cs_a_pin);
                    check_field("ud_a_pin", want.ud_a_pin, m_ud_a_pin);
                    check_field("inc_a_pin", want.inc_a_pin, m_inc_a_pin);
                    check_field("cs_b_pin", want.cs_b_pin, m_cs_b_pin);
                    check_field("ud_b_pin", want.ud_b_pin, m_ud_b_pin);
                    check_field("inc_b_pin", want.inc_b_pin, m_inc_b_pin);
                    check_field("tap_a_now", want.tap_a_now, m_tap_a_now);
                    check_field("tap_b_now", want.tap_b_now, m_tap_b_now);
                    check_field("all_done", want.all_done, m_all_done);
                end
            end
            if (s_valid && s_ready === 1'b1) begin
                want = predict_pins(s_opcode, s_chan_sel, s_ohms);
                if (cur_pinned)
                    want = cur_want;
                pending_pins.push_back(want);
            end
        end
    end

    initial begin
        stim_row_t directed[$];
        int        i;
        for (i = 0; i < dupwc_pkg::NCHAN; i++) begin
            chan_ph[i] = dupwc_pkg::PH_IDLE;
            wiper[i]   = dupwc_pkg::TAP_W'(dupwc_pkg::MID_TAP);
            target[i]  = dupwc_pkg::TAP_W'(dupwc_pkg::MID_TAP);
            dir_up[i]  = 1'b0;
            csn[i]     = 1'b1;
        end
        inc_lvl   = 1'b1;
        half_tick = 1'b0;

        // Directed table: fields are ok, cs/ud/inc of A, cs/ud/inc of B, taps, done
        directed.push_back(pinned_row(dupwc_pkg::OP_TICK, 2'd0, 14'd0,
            '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'd128, 8'd128, 1'b1}));
        directed.push_back(pinned_row(dupwc_pkg::OP_REQUEST, 2'd0,
            dupwc_pkg::OHMS_W'(dupwc_pkg::MIN_OHMS),
            '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'd128, 8'd128, 1'b0}));
        directed.push_back(pinned_row(dupwc_pkg::OP_REQUEST, 2'd2, 14'd100,
            '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'd128, 8'd128, 1'b0}));
        directed.push_back(pinned_row(dupwc_pkg::OP_REQUEST, 2'd3, 14'h3FFF,
            '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'd128, 8'd128, 1'b0}));
        directed.push_back(pinned_row(dupwc_pkg::OP_REQUEST, 2'd1,
            dupwc_pkg::OHMS_W'(dupwc_pkg::MAX_OHMS + 1),
            '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'd128, 8'd128, 1'b0}));
        // Target equal to the current tap: channel B goes straight to done
        directed.push_back(pinned_row(dupwc_pkg::OP_REQUEST, 2'd1,
            ohms_for_tap(dupwc_pkg::MID_TAP),
            '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'd128, 8'd128, 1'b0}));
        for (i = 0; i < 6; i++)
            directed.push_back(row_of(dupwc_pkg::OP_TICK, 2'(i), 14'(i * 3001)));
        directed.push_back(row_of(dupwc_pkg::OP_REQUEST, 2'd1,
                                  dupwc_pkg::OHMS_W'(dupwc_pkg::MAX_OHMS)));
        for (i = 0; i < 5; i++)
            directed.push_back(row_of(dupwc_pkg::OP_TICK, 2'd3, 14'h3FFF));
        // Retarget busy channels, reversing direction
        directed.push_back(row_of(dupwc_pkg::OP_REQUEST, 2'd0,
                                  dupwc_pkg::OHMS_W'(dupwc_pkg::MAX_OHMS)));
        for (i = 0; i < 4; i++)
            directed.push_back(row_of(dupwc_pkg::OP_TICK, 2'd1, 14'h2AAA));
        directed.push_back(row_of(dupwc_pkg::OP_REQUEST, 2'd1,
                                  ohms_for_tap(dupwc_pkg::MID_TAP)));
        directed.push_back(row_of(dupwc_pkg::OP_TICK, 2'd2, 14'h1555));

        // Hold reset low, then release it on a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[k])
            send_row(directed[k]);
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = i >= 500 && i < 750;
            send_row(random_row());
        end
        no_idle = 1'b0;
        s_valid <= 1'b0;

        // Drain outstanding results, then allow for trailing activity
        while (pending_pins.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
